// ===== design/mwpo_pkg.sv =====
`default_nettype none
package mwpo_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int PHASE_W    = 32;
  localparam int OUT_W      = 16;
  localparam int LEVEL_W    = 16;
  localparam int PWIDTH_W   = 16;
  localparam int WAVE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;
  localparam logic [31:0] NOISE_SEED  = 32'h0000_ACE1;

  localparam logic [PWIDTH_W-1:0] PW_MIN = 16'd655;
  localparam logic [PWIDTH_W-1:0] PW_MAX = 16'd64880;

  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 16'd32768;
  localparam logic [PWIDTH_W-1:0] PWIDTH_RESET = 16'd32768;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_PULSE    = 3'd4,
    WAVE_NOISE    = 3'd5
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC = 2'd0,
    REG_WAVE_SEL  = 2'd1,
    REG_LEVEL     = 2'd2,
    REG_PWIDTH    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase_increment;
    logic [WAVE_W-1:0]   waveform_select;
    logic [LEVEL_W-1:0]  output_level;
    logic [PWIDTH_W-1:0] pulse_width;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== design/mwpo_front.sv =====
`default_nettype none
module mwpo_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic [mwpo_pkg::PHASE_W-1:0] in_phase,
  input  wire logic [mwpo_pkg::PHASE_W-1:0] phase_increment,
  input  wire mwpo_pkg::q_status_t          q_status,
  output logic                              push,
  output logic [mwpo_pkg::PHASE_W-1:0]      push_phase
);
  import mwpo_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic               accept;

  assign in_ready   = !q_status.full;
  assign accept     = in_valid && in_ready;
  assign push       = accept && (in_kind == KIND_TICK);
  // the sample uses the phase before the step
  assign push_phase = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      if (in_kind == KIND_LOAD) begin
        phase <= in_phase;
      end else begin
        phase <= phase + phase_increment;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mwpo_queue.sv =====
`default_nettype none
module mwpo_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [mwpo_pkg::PHASE_W-1:0] push_phase,
  input  wire logic                         pop,
  output logic [mwpo_pkg::PHASE_W-1:0]      pop_phase,
  output mwpo_pkg::q_status_t               q_status
);
  import mwpo_pkg::*;

  logic [PHASE_W-1:0]  mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_status.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_phase      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/mwpo_back.sv =====
`default_nettype none
module mwpo_back #(
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mwpo_pkg::cfg_t               cfg,
  input  wire mwpo_pkg::q_status_t          q_status,
  input  wire logic [mwpo_pkg::PHASE_W-1:0] pop_phase,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mwpo_pkg::OUT_W-1:0]        out_sample
);
  import mwpo_pkg::*;

  localparam int T     = SINE_TABLE_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int FRAC  = S - 1;
  localparam int N     = 1 << T;
  localparam int PRODW = S + LEVEL_W + 1;
  localparam int QW    = PRODW + 1 - FRAC;

  localparam logic signed [S:0]       FS_W     = (S+1)'(1 << FRAC);
  localparam logic [PRODW:0]          ROUND    = (PRODW+1)'(1 << (FRAC - 1));
  localparam logic signed [QW-1:0]    SAT_MAX  = QW'(32767);
  localparam logic signed [QW-1:0]    SAT_MIN  = -QW'(32768);
  localparam logic [T:0]              N_ADDR   = (T+1)'(N);

  typedef logic [S-1:0] rom_t [0:N];

  // quarter-wave sine, Q30 Taylor series up to x^11, rounded to S-1 fraction bits
  function automatic rom_t build_rom();
    rom_t              r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint unsigned   s;
    longint unsigned   v;
    longint unsigned   one;
    longint unsigned   fs;
    for (int i = 0; i < N; i++) begin
      one = 64'd1 << 30;
      fs  = 64'd1 << FRAC;
      x   = (64'(i) * 64'(HALF_PI_Q30) + 64'(N / 2)) >> T;
      x2  = (x * x) >> 30;
      t   = one - x2 / 110;
      t   = one - ((x2 * t) >> 30) / 72;
      t   = one - ((x2 * t) >> 30) / 42;
      t   = one - ((x2 * t) >> 30) / 20;
      t   = one - ((x2 * t) >> 30) / 6;
      s   = (x * t) >> 30;
      v   = (s * fs + (one >> 1)) >> 30;
      if (v > fs) begin
        v = fs;
      end
      r[i] = v[S-1:0];
    end
    r[N] = S'(1 << FRAC);
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                move;
  logic [T:0]          rom_addr;
  logic [T-1:0]        rom_idx;
  logic [31:0]         lfsr;
  logic [31:0]         lfsr_next;
  logic [PWIDTH_W-1:0] pw_clamped;

  // stage 1
  logic               v1;
  logic [PHASE_W-1:0] p1;
  logic [S-1:0]       rom_q;
  logic [S-1:0]       noise_q;

  // stage 2
  logic                    v2;
  logic signed [S:0]       wave;
  logic signed [PRODW-1:0] prod;

  logic [PRODW:0]      rounded;
  logic signed [QW-1:0] q;
  logic [OUT_W-1:0]    sat;

  // the whole back pipe shifts together whenever the output slot frees up
  assign move = !out_valid || out_ready;
  assign pop  = move && !q_status.empty;

  assign rom_idx  = pop_phase[29 -: T];
  assign rom_addr = pop_phase[30] ? (N_ADDR - {1'b0, rom_idx}) : {1'b0, rom_idx};

  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= NOISE_SEED;
    end else if (pop && (cfg.waveform_select == WAVE_NOISE)) begin
      lfsr <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      p1      <= pop_phase;
      rom_q   <= SINE_ROM[rom_addr];
      noise_q <= lfsr_next[31 -: S];
    end
  end

  always_comb begin
    pw_clamped = cfg.pulse_width;
    if (pw_clamped < PW_MIN) begin
      pw_clamped = PW_MIN;
    end
    if (pw_clamped > PW_MAX) begin
      pw_clamped = PW_MAX;
    end
  end

  always_comb begin
    case (cfg.waveform_select)
      WAVE_SINE: begin
        wave = p1[31] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
      end
      WAVE_SAW: begin
        wave = FS_W - $signed({1'b0, p1[31 -: S]});
      end
      WAVE_SQUARE: begin
        wave = p1[31] ? -FS_W : FS_W;
      end
      WAVE_TRIANGLE: begin
        // rising half: ramp - FS; falling half: FS - (ramp - 2^S)
        if (!p1[31]) begin
          wave = $signed({1'b0, p1[30 -: S]}) - FS_W;
        end else begin
          wave = FS_W - $signed({1'b0, p1[30 -: S]});
        end
      end
      WAVE_PULSE: begin
        wave = (p1[31:16] < pw_clamped) ? FS_W : -FS_W;
      end
      WAVE_NOISE: begin
        wave = $signed({1'b0, noise_q}) - FS_W;
      end
      default: begin
        wave = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (move) begin
      prod <= PRODW'(wave) * PRODW'($signed({1'b0, cfg.output_level}));
    end
  end

  // round half up, then clamp to the 16-bit range
  always_comb begin
    rounded = {prod[PRODW-1], prod} + ROUND;
    q       = $signed(rounded[PRODW:FRAC]);
    if (q > SAT_MAX) begin
      sat = SAT_MAX[OUT_W-1:0];
    end else if (q < SAT_MIN) begin
      sat = SAT_MIN[OUT_W-1:0];
    end else begin
      sat = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_sample <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (move) begin
      v1        <= pop;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule
`default_nettype wire

// ===== design/multi_waveform_phase_oscillator.sv =====
`default_nettype none
// Phase-accumulator oscillator (sine, saw, square, triangle, pulse, noise) with a
// stream input and a stream output. Each input word is either a tick (tuser = 0),
// which returns one Q1.15 sample taken from the phase before it advances by
// phase_increment, or a phase load (tuser = 1), which sets the phase and returns
// nothing. The block takes one word per clock while the queue is not full: the
// front end does the 32-bit phase add in its phase register and hands tick phases
// to a four-entry queue; the back end reads the quarter-wave sine ROM through one
// registered port, multiplies by the level and rounds, and a sample passes from the
// queue through the ROM, product and output registers. Output backpressure fills the
// queue before tready drops. Configuration writes are taken at any time (cfg_ready
// is always high) but are meant to be issued only while no tick is in flight.
module multi_waveform_phase_oscillator #(
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [31:0]                     s_axis_tdata,  // [31:0] phase_value
  input  wire logic                            s_axis_tuser,  // [0] kind
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [15:0]                          m_axis_tdata,  // [15:0] sample
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mwpo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mwpo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mwpo_pkg::*;

  cfg_t               cfg;
  q_status_t          q_status;
  logic               push;
  logic [PHASE_W-1:0] push_phase;
  logic               pop;
  logic [PHASE_W-1:0] pop_phase;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_increment <= '0;
      cfg.waveform_select <= WAVE_SINE;
      cfg.output_level    <= LEVEL_RESET;
      cfg.pulse_width     <= PWIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PHASE_INC: cfg.phase_increment <= cfg_data[PHASE_W-1:0];
        REG_WAVE_SEL:  cfg.waveform_select <= cfg_data[WAVE_W-1:0];
        REG_LEVEL:     cfg.output_level    <= cfg_data[LEVEL_W-1:0];
        REG_PWIDTH:    cfg.pulse_width     <= cfg_data[PWIDTH_W-1:0];
        default:       cfg.pulse_width     <= cfg.pulse_width;
      endcase
    end
  end

  mwpo_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_kind         (s_axis_tuser),
    .in_phase        (s_axis_tdata),
    .phase_increment (cfg.phase_increment),
    .q_status        (q_status),
    .push            (push),
    .push_phase      (push_phase)
  );

  mwpo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_phase (push_phase),
    .pop        (pop),
    .pop_phase  (pop_phase),
    .q_status   (q_status)
  );

  mwpo_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_status   (q_status),
    .pop_phase  (pop_phase),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata)
  );

endmodule
`default_nettype wire
